// ----- hdl/pixel_format_converter_top_assert.svh -----
// Assertion macros for the pixel format converter top level.
`ifndef PIXEL_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PFC_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pixel format converter: implication check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PFC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pixel format converter: next-cycle check failed");

`endif

// ----- hdl/pfc_pkg.sv -----
// Types, layout codes and helper functions for the pixel format converter.
package pfc_pkg;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 32;
  localparam int LANES     = 3;
  localparam int NUM_CELLS = CH_W;

  localparam int LANE_R = 0;
  localparam int LANE_G = 1;
  localparam int LANE_B = 2;

  localparam logic [CH_W-1:0] CHAN_MAX = 8'hFF;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_BGRA = 3'd0;
  localparam fmt_t FMT_BGRX = 3'd1;
  localparam fmt_t FMT_RGBA = 3'd2;
  localparam fmt_t FMT_RGBX = 3'd3;
  localparam fmt_t FMT_BGR  = 3'd4;
  localparam fmt_t FMT_RGB  = 3'd5;

  typedef enum logic [1:0] {
    REG_SRC_FORMAT     = 2'd0,
    REG_SRC_ALPHA_MODE = 2'd1,
    REG_DST_FORMAT     = 2'd2,
    REG_DST_ALPHA_MODE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    fmt_t src_format;
    logic src_alpha_mode;
    fmt_t dst_format;
    logic dst_alpha_mode;
  } cfg_t;

  // One color channel on its way through the divider chain.
  typedef struct packed {
    logic [CH_W-1:0] part;  // partial remainder, below alpha unless saturated
    logic [CH_W-1:0] low;   // numerator bits still to shift in
    logic [CH_W-1:0] quo;   // quotient bits so far
    logic [CH_W-1:0] orig;  // channel as read from the source word
    logic            sat;   // quotient would exceed the channel range
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [CH_W-1:0]   alpha;
    logic              bypass;  // keep the channel as read
  } cell_data_t;

  function automatic logic is_bgr_order(fmt_t f);
    return (f == FMT_BGRA) || (f == FMT_BGRX) || (f == FMT_BGR);
  endfunction

  function automatic logic is_rgb_order(fmt_t f);
    return (f == FMT_RGBA) || (f == FMT_RGBX) || (f == FMT_RGB);
  endfunction

  function automatic logic has_alpha(fmt_t f);
    return (f == FMT_BGRA) || (f == FMT_RGBA);
  endfunction

endpackage

// ----- hdl/pixel_format_converter_top.sv -----
// Pixel format converter top level: configuration registers, unpack, divider chain, output.
// Converts one 32-bit pixel a clock between BGRA, BGRX, RGBA, RGBX, BGR and RGB layouts
// (codes 6 and 7 are indexed: channels read as zero, output word is zero), with optional
// unpremultiply of the source and premultiply for the target. The stages are one
// unpack stage, a chain of eight divider cells that each resolve one quotient bit of
// c*255/alpha for all three color channels, one multiply stage and one pack stage that
// also serves as the output register. Every stage has its own valid bit, so a new beat is
// taken each cycle while the chain has room, and a stalled output backs up only as far as
// needed. Write the registers only while no beat is in flight.
`include "pixel_format_converter_top_assert.svh"

module pixel_format_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] pixel_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] pixel_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MID_CELL = pfc_pkg::NUM_CELLS / 2;

  pfc_pkg::cfg_t       cfg;
  pfc_pkg::reg_idx_t   reg_idx;
  logic                cfg_write;
  pfc_pkg::cell_data_t cd [pfc_pkg::NUM_CELLS+1];
  logic                cv [pfc_pkg::NUM_CELLS+1];
  logic                cr [pfc_pkg::NUM_CELLS+1];

  assign pready    = 1'b1;
  assign reg_idx   = pfc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        pfc_pkg::REG_SRC_FORMAT:     cfg.src_format     <= pwdata[2:0];
        pfc_pkg::REG_SRC_ALPHA_MODE: cfg.src_alpha_mode <= pwdata[0];
        pfc_pkg::REG_DST_FORMAT:     cfg.dst_format     <= pwdata[2:0];
        pfc_pkg::REG_DST_ALPHA_MODE: cfg.dst_alpha_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfc_pkg::REG_SRC_FORMAT:     prdata = {29'b0, cfg.src_format};
      pfc_pkg::REG_SRC_ALPHA_MODE: prdata = {31'b0, cfg.src_alpha_mode};
      pfc_pkg::REG_DST_FORMAT:     prdata = {29'b0, cfg.dst_format};
      pfc_pkg::REG_DST_ALPHA_MODE: prdata = {31'b0, cfg.dst_alpha_mode};
      default:                     prdata = '0;
    endcase
  end

  pfc_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pixel     (s_tdata),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < pfc_pkg::NUM_CELLS; i++) begin : g_cell
    pfc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  pfc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cv[pfc_pkg::NUM_CELLS]),
    .in_ready  (cr[pfc_pkg::NUM_CELLS]),
    .in_data   (cd[pfc_pkg::NUM_CELLS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pixel     (m_tdata)
  );

  // an accepted beat lands in the unpack stage
  `PFC_ASSERT_NEXT(a_load, s_tvalid && s_tready, cv[0])
  // a cell that hands off fills its neighbor
  `PFC_ASSERT_NEXT(a_handoff, cv[MID_CELL-1] && cr[MID_CELL], cv[MID_CELL])
  // the last cell keeps its beat while the output side is full
  `PFC_ASSERT_NEXT(a_hold, cv[pfc_pkg::NUM_CELLS] && !cr[pfc_pkg::NUM_CELLS],
                   cv[pfc_pkg::NUM_CELLS])
  // an empty unpack stage always takes a beat
  `PFC_ASSERT_IMP(a_ready, !cv[0], s_tready)

endmodule

// ----- hdl/pfc_unpack.sv -----
// Input stage: splits the source word into channels and seeds the divider chain.
module pfc_unpack (
  input  logic                        clk,
  input  logic                        rst,
  input  pfc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfc_pkg::PIX_W-1:0]   pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfc_pkg::cell_data_t         out_data
);

  pfc_pkg::cell_data_t data_next;
  logic [pfc_pkg::LANES-1:0][pfc_pkg::CH_W-1:0] chan;
  logic [pfc_pkg::CH_W-1:0] alpha;
  logic [2*pfc_pkg::CH_W-1:0] num [pfc_pkg::LANES];
  logic [pfc_pkg::CH_W-1:0] b0, b1, b2, b3;

  assign b0 = pixel[7:0];
  assign b1 = pixel[15:8];
  assign b2 = pixel[23:16];
  assign b3 = pixel[31:24];

  always_comb begin
    chan  = '0;
    alpha = '0;
    if (pfc_pkg::is_bgr_order(cfg.src_format)) begin
      chan[pfc_pkg::LANE_B] = b0;
      chan[pfc_pkg::LANE_G] = b1;
      chan[pfc_pkg::LANE_R] = b2;
      alpha = pfc_pkg::has_alpha(cfg.src_format) ? b3 : pfc_pkg::CHAN_MAX;
    end else if (pfc_pkg::is_rgb_order(cfg.src_format)) begin
      chan[pfc_pkg::LANE_R] = b0;
      chan[pfc_pkg::LANE_G] = b1;
      chan[pfc_pkg::LANE_B] = b2;
      alpha = pfc_pkg::has_alpha(cfg.src_format) ? b3 : pfc_pkg::CHAN_MAX;
    end
  end

  // Numerator c*255 = c*256 - c; quotient overflows when its top byte reaches alpha.
  always_comb begin
    data_next.alpha  = alpha;
    data_next.bypass = !cfg.src_alpha_mode || (alpha == '0);
    for (int i = 0; i < pfc_pkg::LANES; i++) begin
      num[i] = {chan[i], {pfc_pkg::CH_W{1'b0}}} - {{pfc_pkg::CH_W{1'b0}}, chan[i]};
      data_next.lane[i].part = num[i][2*pfc_pkg::CH_W-1:pfc_pkg::CH_W];
      data_next.lane[i].low  = num[i][pfc_pkg::CH_W-1:0];
      data_next.lane[i].quo  = '0;
      data_next.lane[i].orig = chan[i];
      data_next.lane[i].sat  = num[i][2*pfc_pkg::CH_W-1:pfc_pkg::CH_W] >= alpha;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- hdl/pfc_cell.sv -----
// Divider cell: one restoring step, one quotient bit for each color lane.
module pfc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfc_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfc_pkg::cell_data_t out_data
);

  pfc_pkg::cell_data_t data_next;
  logic [pfc_pkg::CH_W:0] rem [pfc_pkg::LANES];
  logic [pfc_pkg::CH_W:0] diff [pfc_pkg::LANES];
  logic                   ge [pfc_pkg::LANES];

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < pfc_pkg::LANES; i++) begin
      // shift the next numerator bit into the partial remainder
      rem[i]  = {in_data.lane[i].part, in_data.lane[i].low[pfc_pkg::CH_W-1]};
      diff[i] = rem[i] - {1'b0, in_data.alpha};
      ge[i]   = rem[i] >= {1'b0, in_data.alpha};
      data_next.lane[i].part = ge[i] ? diff[i][pfc_pkg::CH_W-1:0]
                                     : rem[i][pfc_pkg::CH_W-1:0];
      data_next.lane[i].low  = {in_data.lane[i].low[pfc_pkg::CH_W-2:0], 1'b0};
      data_next.lane[i].quo  = {in_data.lane[i].quo[pfc_pkg::CH_W-2:0], ge[i]};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- hdl/pfc_scale.sv -----
// Output stages: picks the straight channel, premultiplies by alpha, packs the target word.
module pfc_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  pfc_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pfc_pkg::cell_data_t       in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pfc_pkg::PIX_W-1:0] pixel
);

  logic [pfc_pkg::CH_W-1:0]   chan [pfc_pkg::LANES];
  logic [pfc_pkg::CH_W-1:0]   factor;
  logic [2*pfc_pkg::CH_W-1:0] prod [pfc_pkg::LANES];
  logic [pfc_pkg::CH_W-1:0]   alpha;
  logic                       prod_valid;
  logic                       pack_ready;
  logic [2*pfc_pkg::CH_W:0]   sum [pfc_pkg::LANES];
  logic [pfc_pkg::CH_W-1:0]   res [pfc_pkg::LANES];
  logic [pfc_pkg::PIX_W-1:0]  pixel_next;

  // A straight target multiplies by 255 so the shared divide gives the channel back.
  assign factor = cfg.dst_alpha_mode ? in_data.alpha : pfc_pkg::CHAN_MAX;

  always_comb begin
    for (int i = 0; i < pfc_pkg::LANES; i++) begin
      if (in_data.bypass) begin
        chan[i] = in_data.lane[i].orig;
      end else if (in_data.lane[i].sat) begin
        chan[i] = pfc_pkg::CHAN_MAX;
      end else begin
        chan[i] = in_data.lane[i].quo;
      end
    end
  end

  assign in_ready   = !prod_valid || pack_ready;
  assign pack_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      alpha <= in_data.alpha;
      for (int i = 0; i < pfc_pkg::LANES; i++) begin
        prod[i] <= chan[i] * factor;
      end
    end
  end

  // floor(p/255) as (p + 1 + p/256) / 256, exact for p up to 255*255
  always_comb begin
    for (int i = 0; i < pfc_pkg::LANES; i++) begin
      sum[i] = {1'b0, prod[i]} + {{2*pfc_pkg::CH_W{1'b0}}, 1'b1}
             + {{(pfc_pkg::CH_W+1){1'b0}}, prod[i][2*pfc_pkg::CH_W-1:pfc_pkg::CH_W]};
      res[i] = sum[i][2*pfc_pkg::CH_W-1:pfc_pkg::CH_W];
    end
  end

  always_comb begin
    pixel_next = '0;
    if (pfc_pkg::is_bgr_order(cfg.dst_format)) begin
      pixel_next[7:0]   = res[pfc_pkg::LANE_B];
      pixel_next[15:8]  = res[pfc_pkg::LANE_G];
      pixel_next[23:16] = res[pfc_pkg::LANE_R];
    end else if (pfc_pkg::is_rgb_order(cfg.dst_format)) begin
      pixel_next[7:0]   = res[pfc_pkg::LANE_R];
      pixel_next[15:8]  = res[pfc_pkg::LANE_G];
      pixel_next[23:16] = res[pfc_pkg::LANE_B];
    end
    if (pfc_pkg::has_alpha(cfg.dst_format)) begin
      pixel_next[31:24] = alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pack_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && pack_ready) begin
      pixel <= pixel_next;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the pixel format converter: stream driver, result checker, APB setup.
module tb_top;

  localparam pfc_pkg::fmt_t FMT_INDEXED     = 3'd6;
  localparam pfc_pkg::fmt_t FMT_INDEXED_ALT = 3'd7;
  localparam int   STALL_LIMIT     = 4000;
  localparam int   DRAIN_CYCLES    = 20;

  typedef enum logic [1:0] {ORD_NONE, ORD_BGR, ORD_RGB} chan_order_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] pixel_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] pixel_out
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_format_converter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pfc_pkg::cfg_t fmt_cfg = '0;
  logic [31:0]   pixel_feed[$];
  logic [31:0]   expected_pixels[$];
  int unsigned   pixels_queued = 0;
  int unsigned   pixels_taken = 0;
  int unsigned   bad_results = 0;
  int unsigned   quiet_cycles = 0;
  bit            tx_gaps_on = 1'b0;
  bit            rx_gaps_on = 1'b0;
  bit            tx_beat_done = 1'b0;
  int unsigned   tx_gap_left = 0;
  int unsigned   rx_stall_left = 0;
  int unsigned   rx_hold_req = 0;
  int unsigned   rx_hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic chan_order_t layout_order(pfc_pkg::fmt_t f);
    case (f)
      pfc_pkg::FMT_BGRA, pfc_pkg::FMT_BGRX, pfc_pkg::FMT_BGR: return ORD_BGR;
      pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGBX, pfc_pkg::FMT_RGB: return ORD_RGB;
      default:                                                return ORD_NONE;
    endcase
  endfunction

  function automatic bit layout_has_alpha(pfc_pkg::fmt_t f);
    return (f == pfc_pkg::FMT_BGRA) || (f == pfc_pkg::FMT_RGBA);
  endfunction

  function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
    logic [15:0] q;
    if (a == 8'd0) return c;
    q = ({8'd0, c} * 16'd255) / {8'd0, a};
    return (q > 16'd255) ? pfc_pkg::CHAN_MAX : q[7:0];
  endfunction

  function automatic logic [7:0] scale_by_alpha(logic [7:0] c, logic [7:0] a);
    logic [15:0] p;
    p = ({8'd0, c} * {8'd0, a}) / 16'd255;
    return p[7:0];
  endfunction

  function automatic logic [31:0] convert_pixel(logic [31:0] px);
    logic [7:0]  r, g, b, a;
    logic [31:0] word;
    r = '0; g = '0; b = '0; a = '0; word = '0;
    case (layout_order(fmt_cfg.src_format))
      ORD_BGR: begin
        b = px[7:0]; g = px[15:8]; r = px[23:16];
        a = layout_has_alpha(fmt_cfg.src_format) ? px[31:24] : pfc_pkg::CHAN_MAX;
      end
      ORD_RGB: begin
        r = px[7:0]; g = px[15:8]; b = px[23:16];
        a = layout_has_alpha(fmt_cfg.src_format) ? px[31:24] : pfc_pkg::CHAN_MAX;
      end
      default: ;
    endcase
    if (fmt_cfg.src_alpha_mode) begin
      r = unpremultiply(r, a);
      g = unpremultiply(g, a);
      b = unpremultiply(b, a);
    end
    if (fmt_cfg.dst_alpha_mode) begin
      r = scale_by_alpha(r, a);
      g = scale_by_alpha(g, a);
      b = scale_by_alpha(b, a);
    end
    case (layout_order(fmt_cfg.dst_format))
      ORD_BGR: word = {8'd0, r, g, b};
      ORD_RGB: word = {8'd0, b, g, r};
      default: word = '0;
    endcase
    if (layout_order(fmt_cfg.dst_format) != ORD_NONE && layout_has_alpha(fmt_cfg.dst_format))
      word[31:24] = a;
    return word;
  endfunction

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int unsigned pick_gap(bit on);
    int unsigned roll;
    if (!on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    logic [7:0]  a;
    px = $urandom();
    case ($urandom_range(0, 7))
      3: px[31:24] = 8'h00;
      4: px[31:24] = 8'hFF;
      5: begin
        // well-formed premultiplied word: every channel at or below alpha
        a = 8'($urandom_range(1, 255));
        px = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
              8'($urandom_range(0, a))};
      end
      6: for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: px[8*i +: 8] = 8'h00;
          1: px[8*i +: 8] = 8'hFF;
          2: px[8*i +: 8] = 8'h01;
          default: px[8*i +: 8] = 8'hFE;
        endcase
      end
      7: px[31:24] = 8'($urandom_range(1, 4));
      default: ;
    endcase
    return px;
  endfunction

  // Sender: hold the beat until taken, then gap or offer the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !tx_beat_done) begin
    end else begin
      tx_beat_done = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        s_tvalid <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
        s_tdata  <= pixel_feed.pop_front();
        s_tvalid <= 1'b1;
        tx_gap_left = pick_gap(tx_gaps_on);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when asked, else random stalls.
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_stall_left = pick_gap(rx_gaps_on);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_pixels.push_back(convert_pixel(s_tdata));
      pixels_taken++;
      tx_beat_done = 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: unexpected beat, actual %08h", m_tdata);
        bad_results++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata !== want) begin
          $error("pixel_out mismatch: expected %08h, actual %08h", want, m_tdata);
          bad_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_pixel(logic [31:0] px);
    pixel_feed.push_back(px);
    pixels_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixels_taken != pixels_queued || expected_pixels.size() != 0);
  endtask

  task automatic apb_write(pfc_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_format(pfc_pkg::fmt_t src, logic src_pm, pfc_pkg::fmt_t dst,
                            logic dst_pm);
    wait_idle();
    apb_write(pfc_pkg::REG_SRC_FORMAT, 32'(src));
    apb_write(pfc_pkg::REG_SRC_ALPHA_MODE, 32'(src_pm));
    apb_write(pfc_pkg::REG_DST_FORMAT, 32'(dst));
    apb_write(pfc_pkg::REG_DST_ALPHA_MODE, 32'(dst_pm));
    fmt_cfg.src_format     = src;
    fmt_cfg.src_alpha_mode = src_pm;
    fmt_cfg.dst_format     = dst;
    fmt_cfg.dst_alpha_mode = dst_pm;
  endtask

  initial begin
    pfc_pkg::fmt_t src, dst;
    wait (!rst);
    @(posedge clk);

    // Directed: reset layout first, then every layout on both sides.
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hA5C3_0F81);
    set_format(pfc_pkg::FMT_BGRA, 1'b1, pfc_pkg::FMT_RGBA, 1'b0);
    queue_pixel(32'h0080_4020);   // zero alpha keeps channels
    queue_pixel(32'h01FF_0201);   // quotient overflows
    queue_pixel(32'hFF80_4020);
    queue_pixel(32'h8040_4080);
    queue_pixel(32'h0201_0203);
    set_format(pfc_pkg::FMT_RGBX, 1'b1, pfc_pkg::FMT_BGR, 1'b1);
    queue_pixel(32'h7FFF_FFFF);
    queue_pixel(32'h0010_2030);
    set_format(pfc_pkg::FMT_RGBA, 1'b0, pfc_pkg::FMT_BGRA, 1'b1);
    queue_pixel(32'h80FF_00FF);
    queue_pixel(32'h00FF_FFFF);
    queue_pixel(32'hFFFF_FFFF);
    set_format(pfc_pkg::FMT_BGR, 1'b0, pfc_pkg::FMT_RGBX, 1'b0);
    queue_pixel(32'hFF12_3456);
    set_format(FMT_INDEXED, 1'b0, pfc_pkg::FMT_RGBA, 1'b1);
    queue_pixel(32'hDEAD_BEEF);
    set_format(FMT_INDEXED_ALT, 1'b1, pfc_pkg::FMT_BGRX, 1'b0);
    queue_pixel(32'hFFFF_FFFF);
    set_format(pfc_pkg::FMT_RGB, 1'b0, FMT_INDEXED, 1'b0);
    queue_pixel(32'h1122_3344);
    set_format(pfc_pkg::FMT_BGRA, 1'b0, FMT_INDEXED_ALT, 1'b1);
    queue_pixel(32'hFFFF_FFFF);
    set_format(pfc_pkg::FMT_BGRX, 1'b0, pfc_pkg::FMT_RGB, 1'b1);
    queue_pixel(32'h00A0_B0C0);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       set_format(pfc_pkg::FMT_RGB, 1'b1, pfc_pkg::FMT_BGR, 1'b1);
        1:       set_format(pfc_pkg::FMT_BGRA, 1'b1, pfc_pkg::FMT_RGBA, 1'b0);
        2:       set_format(FMT_INDEXED_ALT, 1'b0, pfc_pkg::FMT_BGRA, 1'b1);
        3:       set_format(pfc_pkg::FMT_RGBA, 1'b1, pfc_pkg::FMT_BGRA, 1'b1);
        default: begin
          src = 3'($urandom_range(0, 7));
          dst = 3'($urandom_range(0, 7));
          set_format(src, 1'($urandom()), dst, 1'($urandom()));
        end
      endcase
      @(posedge clk);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 5) begin
        // fill the pipe behind a stalled receiver
        tx_gaps_on = 1'b0;
        rx_hold_req = 300;
      end
      for (int n = 0; n < 45; n++) begin
        queue_pixel(random_pixel());
        // drain fully once mid-phase before sending more
        if (phase == 8 && n == 20) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
